@@ rtl/core/bresenham_line_stepper_macros.svh @@
// Assertion macros shared by the line stepper RTL.
`ifndef BRESENHAM_LINE_STEPPER_MACROS_SVH
`define BRESENHAM_LINE_STEPPER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BLS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define BLS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/bls_pkg.sv @@
// Shared constants and types for the line stepper.
package bls_pkg;

    localparam int COORD_BITS_DEFAULT = 10;
    localparam int OP_FIFO_DEPTH      = 2;

    typedef enum logic
    {
        KIND_LOAD    = 1'b0,
        KIND_ADVANCE = 1'b1
    } kind_t;

endpackage

@@ rtl/core/bls_ifs.sv @@
// Command and pixel stream interfaces of the line stepper.
interface bls_cmd_if #(parameter int COORD_BITS = bls_pkg::COORD_BITS_DEFAULT);
    logic                  valid;
    logic                  ready;
    logic                  kind;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;

    modport source (output valid, kind, x_start, y_start, x_end, y_end, input ready);
    modport sink   (input valid, kind, x_start, y_start, x_end, y_end, output ready);
endinterface

interface bls_pix_if #(parameter int COORD_BITS = bls_pkg::COORD_BITS_DEFAULT);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  last;

    modport source (output valid, pixel_x, pixel_y, last, input ready);
    modport sink   (input valid, pixel_x, pixel_y, last, output ready);
endinterface

@@ rtl/core/bresenham_line_stepper.sv @@
// Top level of the Bresenham line stepper.
//
// Usage:
//   cmd carries one command per transfer. kind = load latches the endpoints
//   x_start/y_start/x_end/y_end and emits the start pixel; kind = advance
//   emits the next pixel of the active line. An advance with no pixels left
//   produces nothing. A load during an active line replaces it at once.
//   pix carries one pixel per transfer; last marks the line end point.
//   Each pixel passes the front register, op queue and output register.
//   Throughput: one command and one pixel per cycle while pix is ready; each
//   step is a single add and sign test on the error term in the back end.
//   A two-entry op queue sits between setup and stepping, and the output
//   register takes a new pixel in the same cycle the old one transfers.
//   When pix stalls, the queue and front register fill and cmd.ready drops;
//   nothing is lost.
//   Reset clears all line state: the block is idle, no pixel pending.
module bresenham_line_stepper #(
    parameter int COORD_BITS = bls_pkg::COORD_BITS_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    bls_cmd_if.sink    cmd,
    bls_pix_if.source  pix
);
    localparam int ERR_BITS = COORD_BITS + 3;
    localparam int OP_BITS  = 1 + 2*COORD_BITS + 3 + COORD_BITS + 3*ERR_BITS;

    logic               push_valid, push_ready;
    logic [OP_BITS-1:0] push_data;
    logic               pop_valid, pop_ready;
    logic [OP_BITS-1:0] pop_data;

    bls_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    bls_fifo #(
        .DATA_BITS (OP_BITS),
        .DEPTH     (bls_pkg::OP_FIFO_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_data  (push_data),
        .rd_valid (pop_valid),
        .rd_ready (pop_ready),
        .rd_data  (pop_data)
    );

    bls_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .pix       (pix)
    );

endmodule

@@ rtl/core/bls_front.sv @@
// Front end: takes commands, computes line setup terms, pushes decoded ops.
module bls_front #(
    parameter int COORD_BITS = bls_pkg::COORD_BITS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    bls_cmd_if.sink           cmd,
    output logic              push_valid,
    input  logic              push_ready,
    output logic [1 + 2*COORD_BITS + 3 + COORD_BITS + 3*(COORD_BITS+3) - 1:0] push_data
);
    localparam int ERR_BITS = COORD_BITS + 3;

    logic                  valid_reg, valid_next;
    logic                  kind_reg, kind_next;
    logic [COORD_BITS-1:0] xs_reg, xs_next;
    logic [COORD_BITS-1:0] ys_reg, ys_next;
    logic [COORD_BITS-1:0] adx_reg, adx_next;
    logic [COORD_BITS-1:0] ady_reg, ady_next;
    logic                  xneg_reg, xneg_next;
    logic                  yneg_reg, yneg_next;

    logic                  accept;
    logic                  x_gt, y_gt;
    logic                  steep;
    logic [COORD_BITS-1:0] major, minor;
    logic [ERR_BITS-1:0]   minor2, major1, major2;
    logic [ERR_BITS-1:0]   err_init, inc_ax, inc_dg;

    assign cmd.ready = !valid_reg || push_ready;
    assign accept    = cmd.valid && cmd.ready;

    always_comb
    begin
        x_gt       = cmd.x_end > cmd.x_start;
        y_gt       = cmd.y_end > cmd.y_start;
        valid_next = accept || (valid_reg && !push_ready);
        kind_next  = kind_reg;
        xs_next    = xs_reg;
        ys_next    = ys_reg;
        adx_next   = adx_reg;
        ady_next   = ady_reg;
        xneg_next  = xneg_reg;
        yneg_next  = yneg_reg;
        if (accept)
        begin
            kind_next = cmd.kind;
            xs_next   = cmd.x_start;
            ys_next   = cmd.y_start;
            adx_next  = x_gt ? cmd.x_end - cmd.x_start : cmd.x_start - cmd.x_end;
            ady_next  = y_gt ? cmd.y_end - cmd.y_start : cmd.y_start - cmd.y_end;
            xneg_next = !x_gt;
            yneg_next = !y_gt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        xs_reg   <= xs_next;
        ys_reg   <= ys_next;
        adx_reg  <= adx_next;
        ady_reg  <= ady_next;
        xneg_reg <= xneg_next;
        yneg_reg <= yneg_next;
    end

    // setup terms: err starts at 2*minor - major
    always_comb
    begin
        steep    = ady_reg > adx_reg;
        major    = steep ? ady_reg : adx_reg;
        minor    = steep ? adx_reg : ady_reg;
        minor2   = {2'b00, minor, 1'b0};
        major1   = {3'b000, major};
        major2   = {2'b00, major, 1'b0};
        err_init = minor2 - major1;
        inc_ax   = minor2;
        inc_dg   = minor2 - major2;
    end

    assign push_valid = valid_reg;
    assign push_data  = {kind_reg, xs_reg, ys_reg, xneg_reg, yneg_reg, steep, major,
                         err_init, inc_ax, inc_dg};

endmodule

@@ rtl/core/bls_fifo.sv @@
// Small op queue between the front end and the stepping back end.
module bls_fifo #(
    parameter int DATA_BITS = 8,
    parameter int DEPTH     = bls_pkg::OP_FIFO_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_valid,
    output logic                 wr_ready,
    input  logic [DATA_BITS-1:0] wr_data,
    output logic                 rd_valid,
    input  logic                 rd_ready,
    output logic [DATA_BITS-1:0] rd_data
);
    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [DATA_BITS-1:0] mem_reg [DEPTH];
    logic [PTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]  count_reg, count_next;
    logic                 push, pop;

    assign wr_ready = count_reg < CNT_BITS'(DEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ rtl/core/bls_back.sv @@
// Back end: holds the line state, emits at most one pixel per op, drives the output register.
`include "bresenham_line_stepper_macros.svh"

module bls_back #(
    parameter int COORD_BITS = bls_pkg::COORD_BITS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  logic [1 + 2*COORD_BITS + 3 + COORD_BITS + 3*(COORD_BITS+3) - 1:0] pop_data,
    bls_pix_if.source         pix
);
    localparam int ERR_BITS = COORD_BITS + 3;

    logic                  op_kind;
    logic [COORD_BITS-1:0] op_x, op_y, op_major;
    logic                  op_xneg, op_yneg, op_steep;
    logic [ERR_BITS-1:0]   op_err, op_inc_ax, op_inc_dg;

    logic [COORD_BITS-1:0] cur_x_reg, cur_x_next;
    logic [COORD_BITS-1:0] cur_y_reg, cur_y_next;
    logic [ERR_BITS-1:0]   err_reg, err_next;
    logic [ERR_BITS-1:0]   inc_ax_reg, inc_ax_next;
    logic [ERR_BITS-1:0]   inc_dg_reg, inc_dg_next;
    logic                  xneg_reg, xneg_next;
    logic                  yneg_reg, yneg_next;
    logic                  steep_reg, steep_next;
    logic [COORD_BITS-1:0] remaining_reg, remaining_next;

    logic                  out_valid_reg, out_valid_next;
    logic [COORD_BITS-1:0] pixel_x_reg, pixel_x_next;
    logic [COORD_BITS-1:0] pixel_y_reg, pixel_y_next;
    logic                  last_reg, last_next;

    logic                  pop;
    logic                  is_load, is_adv;
    logic                  diag;
    logic [COORD_BITS-1:0] x_step, y_step;

    assign {op_kind, op_x, op_y, op_xneg, op_yneg, op_steep, op_major,
            op_err, op_inc_ax, op_inc_dg} = pop_data;

    assign pop_ready = !out_valid_reg || pix.ready;
    assign pop       = pop_valid && pop_ready;
    assign is_load   = bls_pkg::kind_t'(op_kind) == bls_pkg::KIND_LOAD;
    assign is_adv    = bls_pkg::kind_t'(op_kind) == bls_pkg::KIND_ADVANCE;

    always_comb
    begin
        diag           = !err_reg[ERR_BITS-1] && (err_reg != '0);
        x_step         = cur_x_reg + (xneg_reg ? {COORD_BITS{1'b1}} : COORD_BITS'(1));
        y_step         = cur_y_reg + (yneg_reg ? {COORD_BITS{1'b1}} : COORD_BITS'(1));
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        err_next       = err_reg;
        inc_ax_next    = inc_ax_reg;
        inc_dg_next    = inc_dg_reg;
        xneg_next      = xneg_reg;
        yneg_next      = yneg_reg;
        steep_next     = steep_reg;
        remaining_next = remaining_reg;
        out_valid_next = out_valid_reg && !pix.ready;
        pixel_x_next   = pixel_x_reg;
        pixel_y_next   = pixel_y_reg;
        last_next      = last_reg;
        if (pop && is_load)
        begin
            cur_x_next     = op_x;
            cur_y_next     = op_y;
            err_next       = op_err;
            inc_ax_next    = op_inc_ax;
            inc_dg_next    = op_inc_dg;
            xneg_next      = op_xneg;
            yneg_next      = op_yneg;
            steep_next     = op_steep;
            remaining_next = op_major;
            out_valid_next = 1'b1;
            pixel_x_next   = op_x;
            pixel_y_next   = op_y;
            last_next      = op_major == '0;
        end
        else if (pop && is_adv && (remaining_reg != '0))
        begin
            if (!steep_reg || diag)
            begin
                cur_x_next = x_step;
            end
            if (steep_reg || diag)
            begin
                cur_y_next = y_step;
            end
            err_next       = err_reg + (diag ? inc_dg_reg : inc_ax_reg);
            remaining_next = remaining_reg - 1'b1;
            out_valid_next = 1'b1;
            pixel_x_next   = cur_x_next;
            pixel_y_next   = cur_y_next;
            last_next      = remaining_reg == COORD_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            err_reg       <= '0;
            inc_ax_reg    <= '0;
            inc_dg_reg    <= '0;
            xneg_reg      <= 1'b0;
            yneg_reg      <= 1'b0;
            steep_reg     <= 1'b0;
            remaining_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            err_reg       <= err_next;
            inc_ax_reg    <= inc_ax_next;
            inc_dg_reg    <= inc_dg_next;
            xneg_reg      <= xneg_next;
            yneg_reg      <= yneg_next;
            steep_reg     <= steep_next;
            remaining_reg <= remaining_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pixel_x_reg <= pixel_x_next;
        pixel_y_reg <= pixel_y_next;
        last_reg    <= last_next;
    end

    assign pix.valid   = out_valid_reg;
    assign pix.pixel_x = pixel_x_reg;
    assign pix.pixel_y = pixel_y_reg;
    assign pix.last    = last_reg;

    `BLS_ASSERT_NEXT(a_idle_advance_silent, clk, rst_n, pop && is_adv && (remaining_reg == '0), !out_valid_reg, "advance while idle produced a pixel")
    `BLS_ASSERT_NEXT(a_load_emits_start, clk, rst_n, pop && is_load, out_valid_reg && (pixel_x_reg == $past(op_x)) && (pixel_y_reg == $past(op_y)), "load did not emit start pixel")
    `BLS_ASSERT_IMPL(a_last_matches_count, clk, rst_n, out_valid_reg, last_reg == (remaining_reg == '0), "last flag disagrees with pixel count")

endmodule

@@ tb/bresenham_line_stepper_tb.sv @@
// Self-checking testbench for the Bresenham line stepper: directed, backpressure and random lines.
`timescale 1ns / 1ps

module bresenham_line_stepper_tb;

    localparam int CB            = bls_pkg::COORD_BITS_DEFAULT;
    localparam int COORD_MAX     = (1 << CB) - 1;
    localparam int RANDOM_ITEMS  = 1650;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 12;
    localparam int TIMEOUT_NS    = 20_000_000;

    typedef struct packed
    {
        logic [CB-1:0] x;
        logic [CB-1:0] y;
        logic          last;
    } pixel_t;

    logic clk;
    logic rst_n;

    bls_cmd_if #(.COORD_BITS(CB)) cmd_bus ();
    bls_pix_if #(.COORD_BITS(CB)) pix_bus ();

    bresenham_line_stepper #(.COORD_BITS(CB)) uut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .pix   (pix_bus)
    );

    pixel_t pixel_q[$];
    int     error_count = 0;
    bit     hold_output = 1'b0;
    bit     burst_mode  = 1'b0;

    // Line walk state of the predictor
    logic [CB-1:0]        walk_x;
    logic [CB-1:0]        walk_y;
    logic [CB-1:0]        span_x;
    logic [CB-1:0]        span_y;
    logic signed [CB+2:0] walk_err;
    logic                 x_down;
    logic                 y_down;
    logic                 walk_steep;
    logic [CB:0]          pixels_left;

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    task automatic predict_pixel(bls_pkg::kind_t k, logic [CB-1:0] xs, logic [CB-1:0] ys,
                                 logic [CB-1:0] xe, logic [CB-1:0] ye);
        int major;
        int minor;
        int e;
        bit diag;
        if (k == bls_pkg::KIND_LOAD)
        begin
            x_down      = !(xe > xs);
            y_down      = !(ye > ys);
            span_x      = (xe > xs) ? xe - xs : xs - xe;
            span_y      = (ye > ys) ? ye - ys : ys - ye;
            walk_steep  = span_y > span_x;
            major       = walk_steep ? span_y : span_x;
            minor       = walk_steep ? span_x : span_y;
            walk_err    = (CB+3)'(2 * minor - major);
            pixels_left = (CB+1)'(major);
            walk_x      = xs;
            walk_y      = ys;
        end
        else
        begin
            if (pixels_left == 0)
                return;
            major = walk_steep ? span_y : span_x;
            minor = walk_steep ? span_x : span_y;
            e     = walk_err;
            diag  = e > 0;
            if (walk_steep || diag)
                walk_y = y_down ? walk_y - 1'b1 : walk_y + 1'b1;
            if (!walk_steep || diag)
                walk_x = x_down ? walk_x - 1'b1 : walk_x + 1'b1;
            walk_err    = diag ? (CB+3)'(e + 2 * minor - 2 * major) : (CB+3)'(e + 2 * minor);
            pixels_left = pixels_left - 1'b1;
        end
        pixel_q.push_back('{walk_x, walk_y, pixels_left == 0});
    endtask

    // Predict on each command transfer, then check each pixel transfer
    always @(posedge clk)
    begin : scoreboard
        pixel_t want;
        if (rst_n)
        begin
            if (cmd_bus.valid && cmd_bus.ready)
                predict_pixel(bls_pkg::kind_t'(cmd_bus.kind), cmd_bus.x_start, cmd_bus.y_start,
                              cmd_bus.x_end, cmd_bus.y_end);
            if (pix_bus.valid && pix_bus.ready)
            begin
                if (pixel_q.size() == 0)
                begin
                    $display("%0t: unexpected pixel x=%0d y=%0d last=%0d", $time,
                             pix_bus.pixel_x, pix_bus.pixel_y, pix_bus.last);
                    error_count++;
                end
                else
                begin
                    want = pixel_q.pop_front();
                    if (pix_bus.pixel_x !== want.x)
                    begin
                        $display("%0t: pixel_x expected %0d actual %0d", $time,
                                 want.x, pix_bus.pixel_x);
                        error_count++;
                    end
                    if (pix_bus.pixel_y !== want.y)
                    begin
                        $display("%0t: pixel_y expected %0d actual %0d", $time,
                                 want.y, pix_bus.pixel_y);
                        error_count++;
                    end
                    if (pix_bus.last !== want.last)
                    begin
                        $display("%0t: last expected %0d actual %0d", $time,
                                 want.last, pix_bus.last);
                        error_count++;
                    end
                end
            end
        end
    end

    // Pixel receiver: random ready pattern, long hold on request
    initial
    begin : pixel_receiver
        int pick;
        int run;
        pix_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_output)
            begin
                hold_output = 1'b0;
                pix_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 65)
                begin
                    pix_bus.ready <= 1'b1;
                    run = $urandom_range(1, 24);
                end
                else if (pick < 95)
                begin
                    pix_bus.ready <= 1'b0;
                    run = $urandom_range(1, 3);
                end
                else
                begin
                    pix_bus.ready <= 1'b0;
                    run = $urandom_range(12, 40);
                end
                repeat (run) @(posedge clk);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic int pick_delta();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6)
            return 0;
        else if (r < 78)
            return $urandom_range(1, 12);
        else if (r < 96)
            return $urandom_range(13, 80);
        else if (r < 99)
            return $urandom_range(81, COORD_MAX);
        else
            return COORD_MAX;
    endfunction

    function automatic logic [CB-1:0] pick_end(logic [CB-1:0] s, int d);
        int sv;
        int up;
        int dn;
        sv = s;
        up = sv + d;
        dn = sv - d;
        if (up <= COORD_MAX && (dn < 0 || $urandom_range(0, 1) == 1))
            return CB'(up);
        else if (dn >= 0)
            return CB'(dn);
        else
            return ($urandom_range(0, 1) == 1) ? CB'(COORD_MAX) : '0;
    endfunction

    function automatic int span_of(logic [CB-1:0] a, logic [CB-1:0] b);
        return (b > a) ? b - a : a - b;
    endfunction

    task automatic send_cmd(bls_pkg::kind_t k, logic [CB-1:0] xs, logic [CB-1:0] ys,
                            logic [CB-1:0] xe, logic [CB-1:0] ye);
        int gap;
        cmd_bus.valid   <= 1'b1;
        cmd_bus.kind    <= k;
        cmd_bus.x_start <= xs;
        cmd_bus.y_start <= ys;
        cmd_bus.x_end   <= xe;
        cmd_bus.y_end   <= ye;
        do
            @(posedge clk);
        while (!cmd_bus.ready);
        if (!burst_mode)
        begin
            gap = pick_gap();
            if (gap > 0)
            begin
                cmd_bus.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Advance commands carry random, ignored coordinates
    task automatic step_line(int n);
        for (int i = 0; i < n; i++)
            send_cmd(bls_pkg::KIND_ADVANCE, CB'($urandom), CB'($urandom), CB'($urandom),
                     CB'($urandom));
    endtask

    task automatic test_idle_advance();
        step_line(1);
    endtask

    task automatic test_degenerate_lines();
        send_cmd(bls_pkg::KIND_LOAD, 0, 0, 0, 0);
        step_line(1);
        send_cmd(bls_pkg::KIND_LOAD, CB'(COORD_MAX), CB'(COORD_MAX), CB'(COORD_MAX),
                 CB'(COORD_MAX));
    endtask

    // Full-range endpoints; each later load replaces the active line
    task automatic test_extreme_lines();
        send_cmd(bls_pkg::KIND_LOAD, 0, CB'(COORD_MAX), CB'(COORD_MAX), 0);
        step_line(2);
        send_cmd(bls_pkg::KIND_LOAD, CB'(COORD_MAX), 0, 0, CB'(COORD_MAX));
        step_line(1);
        send_cmd(bls_pkg::KIND_LOAD, CB'(COORD_MAX), 0, CB'(COORD_MAX - 3), CB'(COORD_MAX));
        step_line(2);
    endtask

    task automatic test_axis_lines();
        send_cmd(bls_pkg::KIND_LOAD, 5, 9, 5, 6);
        step_line(4);
        send_cmd(bls_pkg::KIND_LOAD, 700, 300, 704, 300);
        step_line(4);
    endtask

    task automatic test_output_backpressure();
        cmd_bus.valid <= 1'b0;
        @(posedge clk);
        hold_output = 1'b1;
        wait (hold_output == 1'b0);
        burst_mode = 1'b1;
        send_cmd(bls_pkg::KIND_LOAD, 100, 100, 140, 117);
        step_line(40);
        burst_mode = 1'b0;
    endtask

    task automatic test_random_lines();
        int sent;
        int r;
        int d_x;
        int d_y;
        int major;
        int walk;
        logic [CB-1:0] xs;
        logic [CB-1:0] ys;
        logic [CB-1:0] xe;
        logic [CB-1:0] ye;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
            begin
                step_line($urandom_range(1, 4));
            end
            else if (r < 12)
            begin
                // broken sequence: arbitrary endpoints, abandoned early
                send_cmd(bls_pkg::KIND_LOAD, CB'($urandom), CB'($urandom), CB'($urandom),
                         CB'($urandom));
                walk = $urandom_range(0, 3);
                step_line(walk);
                sent += 1 + walk;
            end
            else
            begin
                xs  = CB'($urandom);
                ys  = CB'($urandom);
                d_x = pick_delta();
                d_y = ($urandom_range(0, 9) == 0) ? d_x : pick_delta();
                xe  = pick_end(xs, d_x);
                ye  = pick_end(ys, d_y);
                major = span_of(xs, xe);
                if (span_of(ys, ye) > major)
                    major = span_of(ys, ye);
                send_cmd(bls_pkg::KIND_LOAD, xs, ys, xe, ye);
                r = $urandom_range(0, 99);
                if (r < 15)
                    walk = $urandom_range(0, major);
                else if (r < 85)
                    walk = major;
                else
                    walk = major + $urandom_range(1, 2);
                step_line(walk);
                sent += 1 + ((walk < major) ? walk : major);
            end
        end
    endtask

    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("Verification failed");
        $finish;
    end

    initial
    begin : main_sequence
        int waited;
        rst_n           <= 1'b0;
        cmd_bus.valid   <= 1'b0;
        cmd_bus.kind    <= bls_pkg::KIND_LOAD;
        cmd_bus.x_start <= '0;
        cmd_bus.y_start <= '0;
        cmd_bus.x_end   <= '0;
        cmd_bus.y_end   <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_idle_advance();
        test_degenerate_lines();
        test_extreme_lines();
        test_axis_lines();
        test_output_backpressure();
        test_random_lines();

        cmd_bus.valid <= 1'b0;
        #1;
        waited = 0;
        while (pixel_q.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            #1;
            waited++;
        end
        if (pixel_q.size() != 0)
        begin
            $display("%0t: %0d expected pixels never arrived", $time, pixel_q.size());
            error_count++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        #1;
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
